// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the aligner checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bosa_pkg.sv =====
`timescale 1ns / 1ps

package bosa_pkg;

    // Hunt, sync-byte checking and payload delivery.
    typedef enum logic [1:0] {
        MODE_HUNT    = 2'd0,
        MODE_SYNC    = 2'd1,
        MODE_PAYLOAD = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SYNC_WORD    = 2'd0,
        CFG_SYNC_LENGTH  = 2'd1,
        CFG_FRAME_LENGTH = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] SYNC_WORD_RST    = 32'h0000_AA55;
    localparam logic [2:0]  SYNC_LENGTH_RST  = 3'd2;
    localparam logic [7:0]  FRAME_LENGTH_RST = 8'd2;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [2:0]  sync_length;
        logic [7:0]  frame_length;
    } t_cfg;

    // One payload job: the two bytes that form the output and how to align them.
    typedef struct packed {
        logic [7:0] prev_byte;
        logic [7:0] curr_byte;
        logic [2:0] bit_offset;
        logic       frame_last;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // Byte made of the low 8-k bits of p followed by the high k bits of n.
    function automatic logic [7:0] f_realign(input logic [7:0] p, input logic [7:0] n,
                                             input logic [2:0] k);
        logic [15:0] w;
        w = {p, n} << k;
        return w[15:8];
    endfunction

endpackage

// ===== rtl/core/bosa_if.sv =====
`timescale 1ns / 1ps

// Input channel: one received byte per item.
interface bosa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// Output channel: one realigned payload byte per item.
interface bosa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [2:0] bit_offset;
    logic       frame_last;

    modport source (output valid, output payload_byte, output bit_offset,
                    output frame_last, input ready);
    modport sink   (input valid, input payload_byte, input bit_offset,
                    input frame_last, output ready);
endinterface

// ===== rtl/core/bosa_front.sv =====
`timescale 1ns / 1ps

module bosa_front
    import bosa_pkg::*;
#(
    parameter int MAX_SYNC_BYTES = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    bosa_in_if.sink        i_in,
    output t_push          o_push,
    input  logic           i_push_ready
);

    localparam int LW = $clog2(MAX_SYNC_BYTES + 1);

    t_mode          r_mode, n_mode;
    logic [7:0]     r_prev, n_prev;
    logic           r_have, n_have;
    logic [2:0]     r_off, n_off;
    logic [LW-1:0]  r_pos, n_pos;
    logic [7:0]     r_cnt, n_cnt;

    logic           w_accept;
    logic           w_step;
    logic [LW-1:0]  w_len;
    logic [7:0]     w_frame_len;
    logic           w_last;
    logic [LW:0]    w_pos_inc;
    logic [7:0]     w_target;
    logic [7:0]     w_expect;
    logic [7:0]     w_cand;
    logic           w_sync_ok;
    logic           w_hit;
    logic [2:0]     w_hit_off;
    int             w_first_idx;
    int             w_pos_idx;

    // Accept whenever the queue has room.
    assign i_in.ready = i_push_ready;
    assign w_accept   = i_in.valid && i_push_ready;
    assign w_step     = w_accept && r_have;

    // Effective lengths and frame-end detection.
    always_comb begin
        if (i_cfg.sync_length == 3'd0) begin
            w_len = LW'(1);
        end else if (int'(i_cfg.sync_length) > MAX_SYNC_BYTES) begin
            w_len = LW'(MAX_SYNC_BYTES);
        end else begin
            w_len = LW'(i_cfg.sync_length);
        end
        w_frame_len = (i_cfg.frame_length == 8'd0) ? 8'd1 : i_cfg.frame_length;
        w_last      = ({1'b0, r_cnt} + 9'd1) >= {1'b0, w_frame_len};
        w_pos_inc   = {1'b0, r_pos} + (LW + 1)'(1);
    end

    // Expected sync bytes: the first one for hunting, the current one while syncing.
    always_comb begin
        w_first_idx = int'(w_len) - 1;
        w_pos_idx   = int'(w_len) - 1 - int'(r_pos);
        w_target    = 8'h00;
        w_expect    = 8'h00;
        for (int j = 0; j < 4; j++) begin
            if (w_first_idx == j) begin
                w_target = i_cfg.sync_word[8*j +: 8];
            end
            if (w_pos_idx == j) begin
                w_expect = i_cfg.sync_word[8*j +: 8];
            end
        end
        w_cand    = f_realign(r_prev, i_in.data_byte, r_off);
        w_sync_ok = (r_pos < w_len) && (w_cand == w_expect);
    end

    // Eight offsets compared in parallel; the lowest matching offset wins.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_off = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (f_realign(r_prev, i_in.data_byte, 3'(k)) == w_target) begin
                w_hit     = 1'b1;
                w_hit_off = 3'(k);
            end
        end
    end

    // Next mode.
    always_comb begin
        n_mode = r_mode;
        if (w_step) begin
            case (r_mode)
                MODE_PAYLOAD: begin
                    if (w_last) begin
                        n_mode = MODE_HUNT;
                    end
                end
                MODE_SYNC: begin
                    if (!w_sync_ok) begin
                        n_mode = MODE_HUNT;
                    end else if (w_pos_inc >= {1'b0, w_len}) begin
                        n_mode = MODE_PAYLOAD;
                    end
                end
                MODE_HUNT: begin
                    if (w_hit) begin
                        n_mode = (w_len == LW'(1)) ? MODE_PAYLOAD : MODE_SYNC;
                    end
                end
                default: begin
                    n_mode = MODE_HUNT;
                end
            endcase
        end
    end

    // Datapath state and the item handed to the queue.
    always_comb begin
        n_prev = w_accept ? i_in.data_byte : r_prev;
        n_have = r_have || w_accept;
        n_off  = r_off;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        o_push.valid          = 1'b0;
        o_push.cmd.prev_byte  = r_prev;
        o_push.cmd.curr_byte  = i_in.data_byte;
        o_push.cmd.bit_offset = r_off;
        o_push.cmd.frame_last = w_last;
        if (w_step) begin
            case (r_mode)
                MODE_PAYLOAD: begin
                    o_push.valid = 1'b1;
                    n_cnt        = w_last ? 8'd0 : r_cnt + 8'd1;
                end
                MODE_SYNC: begin
                    if (w_sync_ok) begin
                        n_pos = w_pos_inc[LW-1:0];
                        if (w_pos_inc >= {1'b0, w_len}) begin
                            n_cnt = 8'd0;
                        end
                    end else begin
                        n_pos = '0;
                    end
                end
                MODE_HUNT: begin
                    if (w_hit) begin
                        n_off = w_hit_off;
                        n_pos = LW'(1);
                        n_cnt = 8'd0;
                    end
                end
                default: begin
                    n_pos = '0;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HUNT;
            r_prev <= 8'd0;
            r_have <= 1'b0;
            r_off  <= 3'd0;
            r_pos  <= '0;
            r_cnt  <= 8'd0;
        end else begin
            r_mode <= n_mode;
            r_prev <= n_prev;
            r_have <= n_have;
            r_off  <= n_off;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/bosa_fifo.sv =====
`timescale 1ns / 1ps

module bosa_fifo
    import bosa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_push_ready,
    output t_push o_head,
    input  logic  i_pop
);

    localparam int DEPTH = 2;

    t_cmd        r_mem [DEPTH];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic        w_pop;

    // Status and head of the queue.
    assign o_push_ready = (r_cnt != 2'(DEPTH));
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rd];
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && o_head.valid;

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== rtl/core/bosa_back.sv =====
`timescale 1ns / 1ps

module bosa_back
    import bosa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_head,
    output logic       o_pop,
    bosa_out_if.source o_out
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_off;
    logic       r_last;

    // Take the next item whenever the output register is empty or being drained.
    assign o_pop = i_head.valid && (!r_valid || o_out.ready);

    assign o_out.valid        = r_valid;
    assign o_out.payload_byte = r_byte;
    assign o_out.bit_offset   = r_off;
    assign o_out.frame_last   = r_last;

    // Realign the byte pair into the output register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= f_realign(i_head.cmd.prev_byte, i_head.cmd.curr_byte,
                                i_head.cmd.bit_offset);
            r_off  <= i_head.cmd.bit_offset;
            r_last <= i_head.cmd.frame_last;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/bit_offset_sync_word_aligner_top.sv =====
`timescale 1ns / 1ps

// Sync word aligner for an MSB-first byte stream: it searches all eight bit offsets at
// once for the first byte of a 1 to 4 byte sync word, checks the remaining sync bytes at
// the offset found, and then delivers frame_length payload bytes realigned to that
// offset, the last one flagged. One input byte is accepted every clock cycle while the
// queue has room; the front end classifies each byte with the eight offset comparators
// running in parallel. A payload item's byte pair enters the queue when its byte is
// accepted and moves into the output register when that register is empty or being
// drained. A two-entry queue lets the input keep flowing while the output is stalled
// for short spells. Configuration should be written only while no frame is in progress.
module bit_offset_sync_word_aligner_top
    import bosa_pkg::*;
#(
    parameter int MAX_SYNC_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    bosa_in_if.sink               i_in,
    bosa_out_if.source            o_out
);

    t_cfg  r_cfg;
    t_push w_push;
    logic  w_push_ready;
    t_push w_head;
    logic  w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word    <= SYNC_WORD_RST;
            r_cfg.sync_length  <= SYNC_LENGTH_RST;
            r_cfg.frame_length <= FRAME_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_WORD:    r_cfg.sync_word    <= i_cfg_wdata[31:0];
                CFG_SYNC_LENGTH:  r_cfg.sync_length  <= i_cfg_wdata[2:0];
                CFG_FRAME_LENGTH: r_cfg.frame_length <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: offset search and sync tracking.
    bosa_front #(
        .MAX_SYNC_BYTES (MAX_SYNC_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    // Queue between the two halves.
    bosa_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // Back end: realignment and output register.
    bosa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/bosa_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bosa_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_last,
    input logic [2:0] i_out_off
);

    // A stalled output item stays on offer.
    `ASSERT_ON_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output item dropped while stalled")

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_rst_out_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // Reset empties the queue, so input is taken straight away.
    `ASSERT_ALWAYS(a_rst_in_ready, i_clk, !i_rst_n |=> i_in_ready, "input not ready after reset")

    // Within a frame the offset does not change between back-to-back items.
    `ASSERT_ON_CLK(a_frame_offset, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last |=> !i_out_valid || i_out_off == $past(i_out_off), "offset changed inside a frame")

endmodule

bind bit_offset_sync_word_aligner_top bosa_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.frame_last),
    .i_out_off   (o_out.bit_offset)
);
